### sv/knn_pkg.sv
// Package with shared types, codes and constants of the k-nearest-neighbor point store.
package knn_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned DIST_W  = 34;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned CLS_W   = 3;
  localparam int unsigned ONE_Q   = 16384;

  typedef enum logic [2:0] {
    ACT_APPEND_PIXEL = 3'd0,
    ACT_APPEND_NORM  = 3'd1,
    ACT_REMOVE_LAST  = 3'd2,
    ACT_SEARCH       = 3'd3,
    ACT_CLASSIFY     = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    REG_NEIGHBOUR_COUNT = 1'd0,
    REG_HALF_WINDOW     = 1'd1
  } reg_index_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [10:0]        pixel_x;
    logic [10:0]        pixel_y;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic [2:0]         point_class;
  } in_req_t;

  typedef struct packed {
    logic [9:0]  neighbour_index;
    logic [32:0] neighbour_distance_sq;
    logic [2:0]  decided_class;
    logic [1:0]  status;
    logic        last;
  } out_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_DECODE,
    S_RD,
    S_WAIT,
    S_INS,
    S_CLS_RD,
    S_CLS_WAIT,
    S_VOTE,
    S_APPEND,
    S_EMIT,
    S_SINGLE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic div_start;
    logic scan_clear;
    logic rd_point;
    logic ins_start;
    logic ins_step;
    logic rd_class;
    logic tally_add;
    logic vote_step;
    logic wr_query;
    logic wr_norm;
    logic count_inc;
    logic count_dec;
    logic emit_load;
    logic emit_next;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic scan_last;
    logic ins_keep;
    logic ins_done;
    logic cls_last;
    logic vote_done;
    logic emit_last;
    logic empty;
    logic full;
    logic decided_zero;
  } stat_t;

endpackage

### sv/knn_point_store_classifier_core.sv
// Top level of the k-nearest-neighbor point store and classifier.
// This block stores up to MAX_POINTS labelled 2-D points in signed Q2.14 and serves one
// request at a time. Every accepted request with a valid action first passes through a
// shared bit-serial divider that turns the pixel coordinates into Q2.14. Appends and
// removals then give their single result once the previous result has left the output
// register. A search or classify walks every stored point through the single read port of
// the point memory: each point is read, its squared distance is registered and compared,
// and when it enters the neighbor list it moves past the larger entries one position at a
// time. Classify then reads the class of each neighbor, votes over the classes and
// appends the query with the decided class when the store is not full and a class was
// decided. Results leave through an output register, one per cycle while the consumer
// keeps out_ready high, and the next request is accepted once the last result of the
// previous one sits in that register and out_ready is high, or the register is empty.
// Configuration writes take effect at once and must be made only while the block is idle.
module knn_point_store_classifier_core #(
  parameter int MAX_POINTS  = 1024,
  parameter int K_MAX       = 16,
  parameter int NUM_CLASSES = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  knn_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output knn_pkg::out_req_t out_data,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [10:0]       cfg_wdata
);

  logic [4:0]  k_r;
  logic [10:0] half_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r    <= 5'd3;
      half_r <= 11'd375;
    end else if (cfg_we) begin
      unique case (cfg_index)
        knn_pkg::REG_NEIGHBOUR_COUNT: k_r    <= cfg_wdata[4:0];
        knn_pkg::REG_HALF_WINDOW:     half_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  knn_pkg::cmd_t  cmd;
  knn_pkg::stat_t stat;
  logic           single_load;
  logic [1:0]     single_status;

  knn_ctrl #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (in_data.action),
    .point_class   (in_data.point_class),
    .stat          (stat),
    .cmd           (cmd),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .single_load   (single_load),
    .single_status (single_status)
  );

  knn_dp #(
    .MAX_POINTS  (MAX_POINTS),
    .K_MAX       (K_MAX),
    .NUM_CLASSES (NUM_CLASSES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_req        (in_data),
    .in_fire       (in_valid && in_ready),
    .cfg_k         (k_r),
    .cfg_half      (half_r),
    .cmd           (cmd),
    .stat          (stat),
    .single_load   (single_load),
    .single_status (single_status),
    .out_req       (out_data)
  );

endmodule

### sv/knn_ctrl.sv
// Controller state machine sequencing appends, removes, scans, votes and result output.
module knn_ctrl #(
  parameter int NUM_CLASSES = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         action,
  input  logic [2:0]         point_class,
  input  knn_pkg::stat_t     stat,
  output knn_pkg::cmd_t      cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               single_load,
  output logic [1:0]         single_status
);

  knn_pkg::state_t state_r, state_nxt;
  logic [2:0] act_r, act_nxt;
  logic [2:0] cls_r, cls_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic       class_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= knn_pkg::S_IDLE;
      act_r    <= 3'd0;
      cls_r    <= 3'd0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      act_r    <= act_nxt;
      cls_r    <= cls_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign class_ok  = (cls_r >= 3'd1) && (32'(cls_r) <= NUM_CLASSES);
  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    cls_nxt       = cls_r;
    ovalid_nxt    = ovalid_r;
    cmd           = '0;
    in_ready      = 1'b0;
    single_load   = 1'b0;
    single_status = knn_pkg::ST_OK;
    if (ovalid_r && out_ready) ovalid_nxt = 1'b0;
    unique case (state_r)
      knn_pkg::S_IDLE: begin
        in_ready = !ovalid_r || out_ready;
        if (in_valid && in_ready) begin
          act_nxt = action;
          cls_nxt = point_class;
          if (action <= knn_pkg::ACT_CLASSIFY) begin
            cmd.div_start = 1'b1;
            state_nxt = knn_pkg::S_DIV;
          end
        end
      end
      knn_pkg::S_DIV: begin
        if (stat.div_done) state_nxt = knn_pkg::S_DECODE;
      end
      knn_pkg::S_DECODE: begin
        // The result register must be free before a single result may be loaded.
        if (!ovalid_r || out_ready) begin
          if (act_r == knn_pkg::ACT_SEARCH || act_r == knn_pkg::ACT_CLASSIFY) begin
            if (stat.empty) begin
              single_status = knn_pkg::ST_EMPTY;
              state_nxt = knn_pkg::S_SINGLE;
            end else begin
              cmd.scan_clear = 1'b1;
              state_nxt = knn_pkg::S_RD;
            end
          end else begin
            state_nxt = knn_pkg::S_SINGLE;
            if (act_r == knn_pkg::ACT_REMOVE_LAST) begin
              if (stat.empty) single_status = knn_pkg::ST_EMPTY;
              else cmd.count_dec = 1'b1;
            end else if (!class_ok) begin
              single_status = knn_pkg::ST_BAD;
            end else if (stat.full) begin
              single_status = knn_pkg::ST_FULL;
            end else begin
              if (act_r == knn_pkg::ACT_APPEND_NORM) cmd.wr_norm = 1'b1;
              else cmd.wr_query = 1'b1;
              cmd.count_inc = 1'b1;
            end
          end
          single_load = (state_nxt == knn_pkg::S_SINGLE);
        end
      end
      knn_pkg::S_RD: begin
        cmd.rd_point = 1'b1;
        state_nxt = knn_pkg::S_WAIT;
      end
      knn_pkg::S_WAIT: begin
        cmd.ins_start = 1'b1;
        state_nxt = knn_pkg::S_INS;
      end
      knn_pkg::S_INS: begin
        if (!stat.ins_keep || stat.ins_done) begin
          cmd.ins_step = 1'b1;
          if (stat.scan_last) begin
            if (act_r == knn_pkg::ACT_CLASSIFY) state_nxt = knn_pkg::S_CLS_RD;
            else state_nxt = knn_pkg::S_EMIT;
          end else begin
            state_nxt = knn_pkg::S_RD;
          end
        end else begin
          cmd.ins_step = 1'b1;
        end
      end
      knn_pkg::S_CLS_RD: begin
        cmd.rd_class = 1'b1;
        state_nxt = knn_pkg::S_CLS_WAIT;
      end
      knn_pkg::S_CLS_WAIT: begin
        cmd.tally_add = 1'b1;
        if (stat.cls_last) state_nxt = knn_pkg::S_VOTE;
        else state_nxt = knn_pkg::S_CLS_RD;
      end
      knn_pkg::S_VOTE: begin
        cmd.vote_step = 1'b1;
        if (stat.vote_done) state_nxt = knn_pkg::S_APPEND;
      end
      knn_pkg::S_APPEND: begin
        if (!stat.full && !stat.decided_zero) begin
          cmd.wr_query  = 1'b1;
          cmd.count_inc = 1'b1;
        end
        state_nxt = knn_pkg::S_EMIT;
      end
      knn_pkg::S_EMIT: begin
        if (!ovalid_r || out_ready) begin
          cmd.emit_load = 1'b1;
          ovalid_nxt = 1'b1;
          if (stat.emit_last) state_nxt = knn_pkg::S_IDLE;
          else cmd.emit_next = 1'b1;
        end
      end
      knn_pkg::S_SINGLE: begin
        if (!ovalid_r || out_ready) begin
          ovalid_nxt = 1'b1;
          state_nxt = knn_pkg::S_IDLE;
        end
      end
      default: state_nxt = knn_pkg::S_IDLE;
    endcase
  end

endmodule

### sv/knn_dp.sv
// Datapath: point memories, pixel divider, distance unit, neighbor list, vote and result register.
module knn_dp #(
  parameter int MAX_POINTS  = 1024,
  parameter int K_MAX       = 16,
  parameter int NUM_CLASSES = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  knn_pkg::in_req_t  in_req,
  input  logic              in_fire,
  input  logic [4:0]        cfg_k,
  input  logic [10:0]       cfg_half,
  input  knn_pkg::cmd_t     cmd,
  output knn_pkg::stat_t    stat,
  input  logic              single_load,
  input  logic [1:0]        single_status,
  output knn_pkg::out_req_t out_req
);

  localparam int PW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int KW = $clog2(K_MAX + 1);
  localparam int LW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int TW = $clog2(K_MAX + 1);
  localparam int NW = $clog2(NUM_CLASSES + 1);

  // Point memories.
  logic signed [15:0] mem_x [MAX_POINTS];
  logic signed [15:0] mem_y [MAX_POINTS];
  logic [2:0]         mem_c [MAX_POINTS];
  logic signed [15:0] rd_x_r, rd_y_r;
  logic [2:0]         rd_c_r;

  logic [CW-1:0] count_r;
  knn_pkg::in_req_t req_r;

  // Shared restoring divider: both pixel ratios in parallel, one bit per cycle.
  logic [24:0] num_x_r, num_y_r;
  logic [11:0] rem_x_r, rem_y_r;
  logic [4:0]  div_cnt_r;
  logic        div_busy_r;
  logic [10:0] h_eff;
  logic [11:0] rx_try, ry_try;
  logic signed [15:0] qx_r, qy_r;
  logic signed [26:0] qx_w, qy_w;

  assign h_eff = (cfg_half == 11'd0) ? 11'd1 : cfg_half;
  assign rx_try = {rem_x_r[10:0], num_x_r[24]};
  assign ry_try = {rem_y_r[10:0], num_y_r[24]};
  assign qx_w = $signed({2'b00, num_x_r}) - 27'sd16384;
  assign qy_w = 27'sd16384 - $signed({2'b00, num_y_r});

  function automatic logic signed [15:0] sat16(input logic signed [26:0] v);
    if (v > 27'sd32767) return 16'sh7fff;
    if (v < -27'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (in_fire) req_r <= in_req;
    if (cmd.div_start) begin
      num_x_r <= {in_req.pixel_x, 14'd0};
      num_y_r <= {in_req.pixel_y, 14'd0};
      rem_x_r <= '0;
      rem_y_r <= '0;
    end else if (div_busy_r) begin
      if (rx_try >= {1'b0, h_eff}) begin
        rem_x_r <= rx_try - {1'b0, h_eff};
        num_x_r <= {num_x_r[23:0], 1'b1};
      end else begin
        rem_x_r <= rx_try;
        num_x_r <= {num_x_r[23:0], 1'b0};
      end
      if (ry_try >= {1'b0, h_eff}) begin
        rem_y_r <= ry_try - {1'b0, h_eff};
        num_y_r <= {num_y_r[23:0], 1'b1};
      end else begin
        rem_y_r <= ry_try;
        num_y_r <= {num_y_r[23:0], 1'b0};
      end
    end
    if (div_busy_r && div_cnt_r == 5'd0) begin
      qx_r <= 16'sd0;
    end
    if (stat.div_done) begin
      qx_r <= sat16(qx_w);
      qy_r <= sat16(qy_w);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_cnt_r  <= '0;
    end else if (cmd.div_start) begin
      div_busy_r <= 1'b1;
      div_cnt_r  <= 5'd25;
    end else if (div_busy_r) begin
      div_cnt_r <= div_cnt_r - 5'd1;
      if (div_cnt_r == 5'd1) div_busy_r <= 1'b0;
    end
  end

  // div_done is seen once the last quotient bit has been shifted in.
  logic div_fin_r;
  always_ff @(posedge clk) begin
    if (!rst_n) div_fin_r <= 1'b0;
    else div_fin_r <= div_busy_r && (div_cnt_r == 5'd1);
  end

  // Effective neighbor count.
  logic [KW-1:0] k_eff;
  always_comb begin
    if (cfg_k == 5'd0) k_eff = KW'(1);
    else if (32'(cfg_k) > K_MAX) k_eff = KW'(K_MAX);
    else k_eff = KW'(cfg_k);
  end

  // Scan over stored points.
  logic [PW-1:0] scan_r;
  logic [CW-1:0] scan_cnt_r;
  logic [PW-1:0] wr_addr;
  logic signed [15:0] wr_x, wr_y;
  logic [2:0] wr_c;
  logic [PW-1:0] rd_addr;
  logic [2:0] decided_r;

  always_comb begin
    wr_addr = count_r[PW-1:0];
    if (cmd.wr_norm) begin
      wr_x = req_r.norm_x;
      wr_y = req_r.norm_y;
      wr_c = req_r.point_class;
    end else begin
      wr_x = qx_r;
      wr_y = qy_r;
      wr_c = (req_r.action == knn_pkg::ACT_CLASSIFY) ? decided_r : req_r.point_class;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_query || cmd.wr_norm) begin
      mem_x[wr_addr] <= wr_x;
      mem_y[wr_addr] <= wr_y;
      mem_c[wr_addr] <= wr_c;
    end
    rd_x_r <= mem_x[rd_addr];
    rd_y_r <= mem_y[rd_addr];
    rd_c_r <= mem_c[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else if (cmd.count_inc) count_r <= count_r + CW'(1);
    else if (cmd.count_dec) count_r <= count_r - CW'(1);
  end

  // Neighbor list (shift-insert, one position per cycle).
  logic [knn_pkg::DIST_W-1:0] bd_r [K_MAX];
  logic [PW-1:0]              bi_r [K_MAX];
  logic [KW-1:0] found_r;
  logic [LW-1:0] pos_r;
  logic [knn_pkg::DIST_W-1:0] d_r;
  logic [PW-1:0] di_r;
  logic          active_r;
  logic signed [16:0] dx, dy;
  logic [33:0] dx2, dy2;

  assign dx  = 17'(rd_x_r) - 17'(qx_r);
  assign dy  = 17'(rd_y_r) - 17'(qy_r);
  assign dx2 = 34'($signed(dx) * $signed(dx));
  assign dy2 = 34'($signed(dy) * $signed(dy));

  always_ff @(posedge clk) begin
    if (cmd.scan_clear) begin
      scan_r     <= '0;
      scan_cnt_r <= CW'(1);
    end else if (cmd.ins_step && !stat.ins_keep || cmd.ins_step && stat.ins_done) begin
      scan_r     <= scan_r + PW'(1);
      scan_cnt_r <= scan_cnt_r + CW'(1);
    end
  end

  // The squares are registered before the add and the list compare.
  logic [33:0] dx2_r, dy2_r;
  logic        sq_v_r;
  always_ff @(posedge clk) begin
    dx2_r <= dx2;
    dy2_r <= dy2;
  end

  logic [knn_pkg::DIST_W-1:0] dist_new;
  assign dist_new = dx2_r + dy2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) sq_v_r <= 1'b0;
    else sq_v_r <= cmd.ins_start;
  end

  // Insertion: on ins_start the squares are not yet ready, so the list update starts
  // on the following cycle (sq_v_r).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r  <= '0;
      active_r <= 1'b0;
    end else begin
      if (cmd.scan_clear) found_r <= '0;
      if (sq_v_r) begin
        d_r  <= dist_new;
        di_r <= scan_r;
        if (found_r < k_eff) begin
          active_r <= 1'b1;
          pos_r    <= LW'(found_r);
          found_r  <= found_r + KW'(1);
        end else if (dist_new < bd_r[LW'(k_eff - KW'(1))]) begin
          active_r <= 1'b1;
          pos_r    <= LW'(k_eff - KW'(1));
        end else begin
          active_r <= 1'b0;
        end
      end else if (active_r) begin
        if (pos_r != '0 && bd_r[pos_r - LW'(1)] > d_r) begin
          bd_r[pos_r] <= bd_r[pos_r - LW'(1)];
          bi_r[pos_r] <= bi_r[pos_r - LW'(1)];
          pos_r <= pos_r - LW'(1);
        end else begin
          bd_r[pos_r] <= d_r;
          bi_r[pos_r] <= di_r;
          active_r <= 1'b0;
        end
      end
    end
  end

  // The controller holds in S_INS while a decision or shift is pending.
  assign stat.ins_keep  = sq_v_r || active_r;
  assign stat.ins_done  = 1'b0;
  assign stat.scan_last = (scan_cnt_r >= count_r);

  // Class tally and vote.
  logic [LW-1:0] emit_r;
  logic [TW-1:0] tally_r [NUM_CLASSES + 1];
  logic [NW-1:0] vote_j_r;
  logic [TW-1:0] vote_best_r;

  assign rd_addr = (cmd.rd_class) ? bi_r[emit_r] : scan_r;

  always_ff @(posedge clk) begin
    if (cmd.scan_clear) begin
      emit_r <= '0;
      for (int c = 0; c <= NUM_CLASSES; c++) tally_r[c] <= '0;
      vote_j_r    <= NW'(1);
      vote_best_r <= '0;
      decided_r   <= '0;
    end else begin
      if (cmd.tally_add) begin
        if (rd_c_r >= 3'd1 && 32'(rd_c_r) <= NUM_CLASSES)
          tally_r[NW'(rd_c_r)] <= tally_r[NW'(rd_c_r)] + TW'(1);
        if (stat.cls_last) emit_r <= '0;
        else emit_r <= emit_r + LW'(1);
      end
      if (cmd.vote_step) begin
        if (tally_r[vote_j_r] > vote_best_r) begin
          vote_best_r <= tally_r[vote_j_r];
          decided_r   <= 3'(vote_j_r);
        end
        vote_j_r <= vote_j_r + NW'(1);
      end
      if (cmd.emit_next) emit_r <= emit_r + LW'(1);
    end
  end

  assign stat.cls_last  = (KW'(emit_r) + KW'(1) >= found_r);
  assign stat.vote_done = (32'(vote_j_r) == NUM_CLASSES);
  assign stat.emit_last = (KW'(emit_r) + KW'(1) >= found_r);
  assign stat.empty     = (count_r == '0);
  assign stat.full      = (32'(count_r) >= MAX_POINTS);
  assign stat.decided_zero = (decided_r == 3'd0);
  assign stat.div_done  = div_fin_r;

  // Status of a classify sweep is latched before the append changes the count.
  logic full_latch_r;
  always_ff @(posedge clk) begin
    if (cmd.scan_clear) full_latch_r <= stat.full;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (single_load) begin
      out_req.neighbour_distance_sq <= '0;
      out_req.decided_class         <= '0;
      out_req.status                <= single_status;
      out_req.last                  <= 1'b1;
      if (single_status == knn_pkg::ST_OK) begin
        out_req.neighbour_index <= (req_r.action == knn_pkg::ACT_REMOVE_LAST) ?
                                   10'(count_r - CW'(1)) : 10'(count_r);
      end else begin
        out_req.neighbour_index <= '0;
      end
    end else if (cmd.emit_load) begin
      out_req.neighbour_index       <= 10'(bi_r[emit_r]);
      out_req.neighbour_distance_sq <= bd_r[emit_r][32:0];
      out_req.decided_class         <= (req_r.action == knn_pkg::ACT_CLASSIFY) ?
                                       decided_r : 3'd0;
      out_req.status <= (req_r.action == knn_pkg::ACT_CLASSIFY && full_latch_r) ?
                        knn_pkg::ST_FULL : knn_pkg::ST_OK;
      out_req.last   <= stat.emit_last;
    end
  end

endmodule
